### src/trs_pkg.sv
// Shared constants, types and helpers for the model matrix builder.
package trs_pkg;

	localparam int NSTEP = 20;

	typedef logic signed [31:0] q16_t;
	typedef logic signed [25:0] deg_t;
	typedef logic signed [33:0] crd_t;
	typedef logic signed [32:0] rot_t;

	// Angle constants in Q16.16 degrees
	localparam logic [31:0] DEG360_U = 32'd23592960;
	localparam deg_t DEG360 = 26'sd23592960;
	localparam deg_t DEG180 = 26'sd11796480;
	localparam deg_t DEG90 = 26'sd5898240;
	// Offset of 2^31 modulo 360 degrees
	localparam deg_t BIAS_MOD = 26'sd524288;
	// CORDIC start vector length, Q2.30
	localparam crd_t CORDIC_GAIN = 34'sd652032874;

	localparam deg_t ATAN [NSTEP] = '{
		26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379,
		26'sd117304, 26'sd58666, 26'sd29335, 26'sd14668, 26'sd7334,
		26'sd3667, 26'sd1833, 26'sd917, 26'sd458, 26'sd229,
		26'sd115, 26'sd57, 26'sd29, 26'sd14, 26'sd7
	};

	// Q2.30 product, rounded to nearest with ties up
	function automatic q16_t mul30(input q16_t a, input q16_t b);
		logic signed [63:0] p;
		begin
			p = a * b;
			p = p + 64'sd536870912;
			return p[61:30];
		end
	endfunction

endpackage

### src/trs_angle_reduce.sv
// Three-stage angle reduction modulo 360 degrees and fold into [-90,90].
module trs_angle_reduce (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            v_in,
	input  trs_pkg::q16_t   ang [3],
	output logic            v_out,
	output trs_pkg::deg_t   z [3],
	output logic            neg [3]
);

	logic [2:0]  v_s;
	logic [31:0] u1 [3];
	logic [31:0] u_s1 [3];
	logic [24:0] u2 [3];
	logic [24:0] u_s2 [3];
	trs_pkg::deg_t r3 [3];
	logic          n3 [3];
	trs_pkg::deg_t z_s3 [3];
	logic          neg_s3 [3];

	// Remove multiples of 360 * 128 down to 360 * 16 from the biased angle
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			u1[j] = {~ang[j][31], ang[j][30:0]};
			for (int k = 7; k >= 4; k--) begin
				if (u1[j] >= (trs_pkg::DEG360_U << k))
					u1[j] = u1[j] - (trs_pkg::DEG360_U << k);
			end
		end
	end

	// Remove multiples of 360 * 8 down to 360
	always_comb begin
		logic [31:0] t;
		for (int j = 0; j < 3; j++) begin
			t = u_s1[j];
			for (int k = 3; k >= 0; k--) begin
				if (t >= (trs_pkg::DEG360_U << k))
					t = t - (trs_pkg::DEG360_U << k);
			end
			u2[j] = t[24:0];
		end
	end

	// Undo the bias, then fold into [-90,90]
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			r3[j] = $signed({1'b0, u_s2[j]}) - trs_pkg::BIAS_MOD;
			if (r3[j] < 0)
				r3[j] = r3[j] + trs_pkg::DEG360;
			if (r3[j] > trs_pkg::DEG180)
				r3[j] = r3[j] - trs_pkg::DEG360;
			n3[j] = 1'b0;
			if (r3[j] > trs_pkg::DEG90) begin
				r3[j] = r3[j] - trs_pkg::DEG180;
				n3[j] = 1'b1;
			end else if (r3[j] < -trs_pkg::DEG90) begin
				r3[j] = r3[j] + trs_pkg::DEG180;
				n3[j] = 1'b1;
			end
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[1:0], v_in};
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			u_s1   <= u1;
			u_s2   <= u2;
			z_s3   <= r3;
			neg_s3 <= n3;
		end
	end

	assign v_out = v_s[2];
	assign z     = z_s3;
	assign neg   = neg_s3;

endmodule

### src/trs_cordic.sv
// Pipelined rotation-mode CORDIC in degrees, one step per stage, three lanes.
module trs_cordic (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            v_in,
	input  trs_pkg::deg_t   z_in [3],
	input  logic            neg_in [3],
	output logic            v_out,
	output trs_pkg::q16_t   sn [3],
	output trs_pkg::q16_t   cs [3]
);

	localparam int NSTEP = trs_pkg::NSTEP;

	logic [NSTEP:0] v_s;
	trs_pkg::crd_t x_s [NSTEP][3];
	trs_pkg::crd_t y_s [NSTEP][3];
	trs_pkg::deg_t z_s [NSTEP][3];
	logic          n_s [NSTEP][3];
	trs_pkg::q16_t sn_s [3];
	trs_pkg::q16_t cs_s [3];

	for (genvar i = 0; i < NSTEP; i++) begin : g_step
		trs_pkg::crd_t xi [3];
		trs_pkg::crd_t yi [3];
		trs_pkg::deg_t zi [3];
		logic          ni [3];

		if (i == 0) begin : g_first
			assign xi = '{default: trs_pkg::CORDIC_GAIN};
			assign yi = '{default: '0};
			assign zi = z_in;
			assign ni = neg_in;
		end else begin : g_next
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
			assign ni = n_s[i-1];
		end

		// Rotate toward zero residual angle
		always_ff @(posedge clk) begin
			if (en) begin
				for (int j = 0; j < 3; j++) begin
					if (zi[j] >= 0) begin
						x_s[i][j] <= xi[j] - (yi[j] >>> i);
						y_s[i][j] <= yi[j] + (xi[j] >>> i);
						z_s[i][j] <= zi[j] - trs_pkg::ATAN[i];
					end else begin
						x_s[i][j] <= xi[j] + (yi[j] >>> i);
						y_s[i][j] <= yi[j] - (xi[j] >>> i);
						z_s[i][j] <= zi[j] + trs_pkg::ATAN[i];
					end
					n_s[i][j] <= ni[j];
				end
			end
		end
	end

	// Apply the half-turn sign flip
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				sn_s[j] <= n_s[NSTEP-1][j] ? 32'(-y_s[NSTEP-1][j]) : 32'(y_s[NSTEP-1][j]);
				cs_s[j] <= n_s[NSTEP-1][j] ? 32'(-x_s[NSTEP-1][j]) : 32'(x_s[NSTEP-1][j]);
			end
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[NSTEP-1:0], v_in};
		end
	end

	assign v_out = v_s[NSTEP];
	assign sn    = sn_s;
	assign cs    = cs_s;

endmodule

### src/trs_matrix_mul.sv
// Five-stage product pipeline: rotation terms, scaling, rounding, saturation.
module trs_matrix_mul (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            v_in,
	input  trs_pkg::q16_t   sn [3],
	input  trs_pkg::q16_t   cs [3],
	input  trs_pkg::q16_t   scl_in [3],
	input  trs_pkg::q16_t   pos_in [3],
	output logic            v_out,
	output trs_pkg::q16_t   ent [3][4]
);

	logic [4:0] v_s;

	// Stage 1 products
	trs_pkg::q16_t cycz_s1, cysz_s1, t1_s1, t2_s1, cxsz_s1, cxcz_s1;
	trs_pkg::q16_t sxcy_s1, sxsz_s1, sxcz_s1, cxcy_s1, sy_s1, cz_s1, sz_s1;
	trs_pkg::q16_t scl_s1 [3], pos_s1 [3];
	// Stage 2 products
	trs_pkg::q16_t t1cz_s2, t1sz_s2, t2cz_s2, t2sz_s2;
	trs_pkg::q16_t cycz_s2, cysz_s2, cxsz_s2, cxcz_s2;
	trs_pkg::q16_t sxcy_s2, sxsz_s2, sxcz_s2, cxcy_s2, sy_s2;
	trs_pkg::q16_t scl_s2 [3], pos_s2 [3];
	// Stage 3 rotation matrix
	trs_pkg::rot_t rm_s3 [3][3];
	trs_pkg::q16_t scl_s3 [3], pos_s3 [3];
	// Stage 4 scaled products
	logic signed [64:0] pr_s4 [3][3];
	trs_pkg::q16_t pos_s4 [3];
	// Stage 5 rounded entries
	trs_pkg::q16_t ent_s5 [3][4];

	always_ff @(posedge clk) begin
		logic signed [64:0] r;
		if (en) begin
			// Form two-factor rotation terms
			cycz_s1 <= trs_pkg::mul30(cs[1], cs[2]);
			cysz_s1 <= trs_pkg::mul30(cs[1], sn[2]);
			t1_s1   <= trs_pkg::mul30(sn[0], sn[1]);
			t2_s1   <= trs_pkg::mul30(cs[0], sn[1]);
			cxsz_s1 <= trs_pkg::mul30(cs[0], sn[2]);
			cxcz_s1 <= trs_pkg::mul30(cs[0], cs[2]);
			sxcy_s1 <= trs_pkg::mul30(sn[0], cs[1]);
			sxsz_s1 <= trs_pkg::mul30(sn[0], sn[2]);
			sxcz_s1 <= trs_pkg::mul30(sn[0], cs[2]);
			cxcy_s1 <= trs_pkg::mul30(cs[0], cs[1]);
			sy_s1   <= sn[1];
			cz_s1   <= cs[2];
			sz_s1   <= sn[2];
			scl_s1  <= scl_in;
			pos_s1  <= pos_in;

			// Form three-factor terms
			t1cz_s2 <= trs_pkg::mul30(t1_s1, cz_s1);
			t1sz_s2 <= trs_pkg::mul30(t1_s1, sz_s1);
			t2cz_s2 <= trs_pkg::mul30(t2_s1, cz_s1);
			t2sz_s2 <= trs_pkg::mul30(t2_s1, sz_s1);
			cycz_s2 <= cycz_s1;
			cysz_s2 <= cysz_s1;
			cxsz_s2 <= cxsz_s1;
			cxcz_s2 <= cxcz_s1;
			sxcy_s2 <= sxcy_s1;
			sxsz_s2 <= sxsz_s1;
			sxcz_s2 <= sxcz_s1;
			cxcy_s2 <= cxcy_s1;
			sy_s2   <= sy_s1;
			scl_s2  <= scl_s1;
			pos_s2  <= pos_s1;

			// Combine into the rotation matrix
			rm_s3[0][0] <= 33'(cycz_s2);
			rm_s3[0][1] <= -33'(cysz_s2);
			rm_s3[0][2] <= 33'(sy_s2);
			rm_s3[1][0] <= 33'(cxsz_s2) + 33'(t1cz_s2);
			rm_s3[1][1] <= 33'(cxcz_s2) - 33'(t1sz_s2);
			rm_s3[1][2] <= -33'(sxcy_s2);
			rm_s3[2][0] <= 33'(sxsz_s2) - 33'(t2cz_s2);
			rm_s3[2][1] <= 33'(sxcz_s2) + 33'(t2sz_s2);
			rm_s3[2][2] <= 33'(cxcy_s2);
			scl_s3 <= scl_s2;
			pos_s3 <= pos_s2;

			// Scale each column
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 3; j++)
					pr_s4[k][j] <= rm_s3[k][j] * 65'(scl_s3[j]);
			end
			pos_s4 <= pos_s3;

			// Round to Q16.16 and saturate
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 3; j++) begin
					r = pr_s4[k][j] + 65'sd536870912;
					if ($signed(r[64:30]) > 35'sd2147483647)
						ent_s5[k][j] <= 32'sh7fffffff;
					else if ($signed(r[64:30]) < -35'sd2147483648)
						ent_s5[k][j] <= 32'sh80000000;
					else
						ent_s5[k][j] <= r[61:30];
				end
				ent_s5[k][3] <= pos_s4[k];
			end
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[3:0], v_in};
		end
	end

	assign v_out = v_s[4];
	assign ent   = ent_s5;

endmodule

### src/trs_row_serial.sv
// Row buffer that sends one matrix as three row requests and backs up the pipeline.
module trs_row_serial (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            v_in,
	input  trs_pkg::q16_t   ent [3][4],
	output logic            en,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [1:0]      row_index,
	output trs_pkg::q16_t   col0,
	output trs_pkg::q16_t   col1,
	output trs_pkg::q16_t   col2,
	output trs_pkg::q16_t   col3,
	output logic            last_row
);

	localparam logic [1:0] LAST_ROW = 2'd2;

	logic          full_q;
	logic [1:0]    row_q;
	trs_pkg::q16_t buf_q [3][4];
	logic          done;
	logic          take;

	// Take a new matrix when the buffer is empty or its last row leaves now
	assign done = full_q && out_ready && (row_q == LAST_ROW);
	assign take = v_in && (!full_q || done);
	assign en   = !v_in || take;

	// Track buffer occupancy and current row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			row_q  <= '0;
		end else if (take) begin
			full_q <= 1'b1;
			row_q  <= '0;
		end else if (done) begin
			full_q <= 1'b0;
			row_q  <= '0;
		end else if (full_q && out_ready) begin
			row_q <= row_q + 2'd1;
		end
	end

	// Load matrix
	always_ff @(posedge clk) begin
		if (take)
			buf_q <= ent;
	end

	assign out_valid = full_q;
	assign row_index = row_q;
	assign col0      = buf_q[row_q][0];
	assign col1      = buf_q[row_q][1];
	assign col2      = buf_q[row_q][2];
	assign col3      = buf_q[row_q][3];
	assign last_row  = (row_q == LAST_ROW);

endmodule

### src/trs_model_matrix_builder.sv
// Registers from request to first row: 3 reduce, 21 CORDIC, 5 product, 1 buffer.
// Throughput: a request may enter every cycle while in_ready is high; the output sends
// three rows per request, so a sustained stream is paced by the rows sent out.
// The row buffer sets the pace; once a finished matrix waits behind a busy row buffer,
// all stages hold until it is taken, while bubbles keep advancing otherwise.
// Reset clears valid bits and the row buffer state; payload is not reset.
module trs_model_matrix_builder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic signed [31:0]  pos_z,
	input  logic signed [31:0]  angle_x_deg,
	input  logic signed [31:0]  angle_y_deg,
	input  logic signed [31:0]  angle_z_deg,
	input  logic signed [31:0]  scale_x,
	input  logic signed [31:0]  scale_y,
	input  logic signed [31:0]  scale_z,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          row_index,
	output logic signed [31:0]  col0,
	output logic signed [31:0]  col1,
	output logic signed [31:0]  col2,
	output logic signed [31:0]  col3,
	output logic                last_row
);

	localparam int DLY = 3 + trs_pkg::NSTEP + 1;

	logic          en;
	logic          v_red, v_cor, v_mul;
	trs_pkg::q16_t ang [3];
	trs_pkg::deg_t z_red [3];
	logic          n_red [3];
	trs_pkg::q16_t sn [3], cs [3];
	trs_pkg::q16_t ent [3][4];
	trs_pkg::q16_t pos_d [DLY][3];
	trs_pkg::q16_t scl_d [DLY][3];

	assign in_ready = en;
	assign ang = '{angle_x_deg, angle_y_deg, angle_z_deg};

	// Carry position and scale alongside the angle stages
	always_ff @(posedge clk) begin
		if (en) begin
			pos_d[0] <= '{pos_x, pos_y, pos_z};
			scl_d[0] <= '{scale_x, scale_y, scale_z};
			for (int k = 1; k < DLY; k++) begin
				pos_d[k] <= pos_d[k-1];
				scl_d[k] <= scl_d[k-1];
			end
		end
	end

	trs_angle_reduce u_red (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (in_valid),
		.ang    (ang),
		.v_out  (v_red),
		.z      (z_red),
		.neg    (n_red)
	);

	trs_cordic u_cor (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (v_red),
		.z_in   (z_red),
		.neg_in (n_red),
		.v_out  (v_cor),
		.sn     (sn),
		.cs     (cs)
	);

	trs_matrix_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (v_cor),
		.sn     (sn),
		.cs     (cs),
		.scl_in (scl_d[DLY-1]),
		.pos_in (pos_d[DLY-1]),
		.v_out  (v_mul),
		.ent    (ent)
	);

	trs_row_serial u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.v_in      (v_mul),
		.ent       (ent),
		.en        (en),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.row_index (row_index),
		.col0      (col0),
		.col1      (col1),
		.col2      (col2),
		.col3      (col3),
		.last_row  (last_row)
	);

endmodule
